// File: hw/rtl/rcmsd_pkg.sv
package rcmsd_pkg;

	localparam int NUM_BOUNDS = 5;
	localparam int THR_W      = 12;
	localparam int BOUND_W    = 2 * THR_W;
	localparam int COUNT_W    = 8;

	typedef logic [2:0]       level_t;
	typedef logic [THR_W-1:0] usec_t;

	localparam level_t MAX_LEVEL = 3'd5;
	localparam level_t ROLL_BASE = 3'd3;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_BOUNDARY_ONE   = 3'd0,
		REG_BOUNDARY_TWO   = 3'd1,
		REG_BOUNDARY_THREE = 3'd2,
		REG_BOUNDARY_FOUR  = 3'd3,
		REG_BOUNDARY_FIVE  = 3'd4,
		REG_CONFIRM_TICKS  = 3'd5,
		REG_VALID_MIN      = 3'd6,
		REG_VALID_MAX      = 3'd7
	} reg_idx_t;

	localparam logic [BOUND_W-1:0] RST_BOUNDARY_ONE   = 24'd5096674;
	localparam logic [BOUND_W-1:0] RST_BOUNDARY_TWO   = 24'd5600605;
	localparam logic [BOUND_W-1:0] RST_BOUNDARY_THREE = 24'd6034887;
	localparam logic [BOUND_W-1:0] RST_BOUNDARY_FOUR  = 24'd6882966;
	localparam logic [BOUND_W-1:0] RST_BOUNDARY_FIVE  = 24'd7706463;
	localparam logic [COUNT_W-1:0] RST_CONFIRM_TICKS  = 8'd3;
	localparam usec_t              RST_VALID_MIN      = 12'd850;
	localparam usec_t              RST_VALID_MAX      = 12'd2150;

	// bits 11:0 upward threshold, bits 23:12 downward threshold
	typedef struct packed {
		logic [NUM_BOUNDS-1:0][BOUND_W-1:0] boundary;
		logic [COUNT_W-1:0]                 confirm_ticks;
		usec_t                              valid_min_us;
		usec_t                              valid_max_us;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         flight_mode;
		logic               roll_on;
		level_t             candidate_level;
		logic [COUNT_W-1:0] confirm_count;
	} res_t;

	// level mod 3
	function automatic logic [1:0] level_mode(input level_t lvl);
		logic [1:0] m;
		case (lvl) inside
			3'd0, 3'd3: m = 2'd0;
			3'd1, 3'd4: m = 2'd1;
			default:    m = 2'd2;
		endcase
		return m;
	endfunction

endpackage

// File: hw/rtl/rcmsd_cfg.sv
module rcmsd_cfg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [2:0]           wr_index,
	input  logic [23:0]          wr_data,
	output rcmsd_pkg::cfg_t      cfg
);

	rcmsd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.boundary[0]   <= rcmsd_pkg::RST_BOUNDARY_ONE;
			cfg_q.boundary[1]   <= rcmsd_pkg::RST_BOUNDARY_TWO;
			cfg_q.boundary[2]   <= rcmsd_pkg::RST_BOUNDARY_THREE;
			cfg_q.boundary[3]   <= rcmsd_pkg::RST_BOUNDARY_FOUR;
			cfg_q.boundary[4]   <= rcmsd_pkg::RST_BOUNDARY_FIVE;
			cfg_q.confirm_ticks <= rcmsd_pkg::RST_CONFIRM_TICKS;
			cfg_q.valid_min_us  <= rcmsd_pkg::RST_VALID_MIN;
			cfg_q.valid_max_us  <= rcmsd_pkg::RST_VALID_MAX;
		end else if (wr_en) begin
			unique case (rcmsd_pkg::reg_idx_t'(wr_index))
				rcmsd_pkg::REG_BOUNDARY_ONE:   cfg_q.boundary[0] <= wr_data;
				rcmsd_pkg::REG_BOUNDARY_TWO:   cfg_q.boundary[1] <= wr_data;
				rcmsd_pkg::REG_BOUNDARY_THREE: cfg_q.boundary[2] <= wr_data;
				rcmsd_pkg::REG_BOUNDARY_FOUR:  cfg_q.boundary[3] <= wr_data;
				rcmsd_pkg::REG_BOUNDARY_FIVE:  cfg_q.boundary[4] <= wr_data;
				rcmsd_pkg::REG_CONFIRM_TICKS:  cfg_q.confirm_ticks <= wr_data[7:0];
				rcmsd_pkg::REG_VALID_MIN:      cfg_q.valid_min_us <= wr_data[11:0];
				rcmsd_pkg::REG_VALID_MAX:      cfg_q.valid_max_us <= wr_data[11:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hw/rtl/rcmsd_core.sv
module rcmsd_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic [11:0]      pulse_us,
	input  logic             signal_lost,
	input  rcmsd_pkg::cfg_t  cfg,
	output rcmsd_pkg::res_t  res
);

	rcmsd_pkg::level_t committed_q, pending_q;
	logic [7:0]        count_q;
	logic              first_q;

	rcmsd_pkg::level_t committed_d, pending_d, cand;
	logic [7:0]        count_d, count_inc;
	logic [rcmsd_pkg::NUM_BOUNDS-1:0] below;
	logic              in_win, frozen;

	// Schmitt decode: a boundary at or above the committed level uses its upward threshold
	always_comb begin
		in_win = (pulse_us >= cfg.valid_min_us) && (pulse_us <= cfg.valid_max_us);
		for (int k = 0; k < rcmsd_pkg::NUM_BOUNDS; k++) begin
			if (committed_q <= rcmsd_pkg::level_t'(k))
				below[k] = pulse_us < cfg.boundary[k][rcmsd_pkg::THR_W-1:0];
			else
				below[k] = pulse_us < cfg.boundary[k][rcmsd_pkg::BOUND_W-1:rcmsd_pkg::THR_W];
		end
		cand = rcmsd_pkg::MAX_LEVEL;
		for (int k = rcmsd_pkg::NUM_BOUNDS - 1; k >= 0; k--) begin
			if (below[k])
				cand = rcmsd_pkg::level_t'(k);
		end
		if (!in_win)
			cand = committed_q;
	end

	assign frozen    = signal_lost || (pulse_us == '0);
	assign count_inc = count_q + 8'd1;

	always_comb begin
		committed_d = committed_q;
		pending_d   = pending_q;
		count_d     = count_q;
		if (!frozen) begin
			if (first_q) begin
				committed_d = cand;
				pending_d   = cand;
				count_d     = cfg.confirm_ticks;
			end else if (cand == pending_q) begin
				if (count_q < cfg.confirm_ticks) begin
					count_d = count_inc;
					if (count_inc >= cfg.confirm_ticks)
						committed_d = cand;
				end
			end else begin
				pending_d = cand;
				count_d   = 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			committed_q <= '0;
			pending_q   <= '0;
			count_q     <= '0;
			first_q     <= 1'b1;
		end else if (advance) begin
			committed_q <= committed_d;
			pending_q   <= pending_d;
			count_q     <= count_d;
			first_q     <= 1'b0;
		end
	end

	assign res.flight_mode     = rcmsd_pkg::level_mode(committed_d);
	assign res.roll_on         = committed_d >= rcmsd_pkg::ROLL_BASE;
	assign res.candidate_level = pending_d;
	assign res.confirm_count   = count_d;

	a_committed_range: assert property (@(posedge clk) disable iff (!arst_n)
		committed_q <= rcmsd_pkg::MAX_LEVEL)
		else $error("committed level out of range");

	a_pending_range: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= rcmsd_pkg::MAX_LEVEL)
		else $error("pending level out of range");

	a_first_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> !first_q)
		else $error("first tick flag not cleared");

	a_frozen_holds: assert property (@(posedge clk) disable iff (!arst_n)
		advance && frozen |=> $stable(committed_q) && $stable(pending_q) && $stable(count_q))
		else $error("state changed on a frozen tick");

	a_new_level_no_commit: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !frozen && !first_q && (cand != pending_q)
		|=> $stable(committed_q) && (count_q == 8'd1))
		else $error("new pending level committed early");

endmodule

// File: hw/rtl/rc_mode_switch_hysteresis_debounce.sv
// RC mode switch decoder. Each transfer on the input channel carries one tick
// (pulse width in microseconds plus a signal-lost flag) and yields exactly one
// result: the committed flight mode and roll switch, the level waiting for
// confirmation and its repeat count. Pulses map onto six levels through five
// boundaries with separate upward and downward thresholds; pulses outside the
// valid window repeat the committed level, and lost or zero pulses freeze the
// committed and pending levels and the repeat count. A tick is accepted every
// clock while the output is not stalled; the result passes through the input
// register, then the result register. The rate is set by the committed/pending
// level and repeat counter updating as each tick advances, read by the next
// tick. Configuration writes must only be issued while no tick is in flight.
module rc_mode_switch_hysteresis_debounce (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [11:0] pulse_us,
	input  logic        signal_lost,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  flight_mode,
	output logic        roll_on,
	output logic [2:0]  candidate_level,
	output logic [7:0]  confirm_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	rcmsd_pkg::cfg_t cfg;
	rcmsd_pkg::res_t res, res_s2;

	logic        valid_s1, valid_s2;
	logic [11:0] pulse_s1;
	logic        lost_s1;
	logic        advance;

	assign cfg_ready = 1'b1;

	rcmsd_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// stage 1 moves on when the result register is empty or being drained
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				valid_s2 <= 1'b1;
			else if (out_ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pulse_s1 <= pulse_us;
			lost_s1  <= signal_lost;
		end
		if (advance)
			res_s2 <= res;
	end

	rcmsd_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.pulse_us    (pulse_s1),
		.signal_lost (lost_s1),
		.cfg         (cfg),
		.res         (res)
	);

	assign out_valid       = valid_s2;
	assign flight_mode     = res_s2.flight_mode;
	assign roll_on         = res_s2.roll_on;
	assign candidate_level = res_s2.candidate_level;
	assign confirm_count   = res_s2.confirm_count;

endmodule
